[sv/gpg_pkg.sv]
`default_nettype none
package gpg_pkg;
	localparam int MAX_POINTS  = 16;
	localparam int MAX_ENTRIES = 4096;
	localparam int SLOT_W      = $clog2(MAX_POINTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int IDX_W       = 12;
	localparam int SIZE_W      = 13;
	localparam int POS_W       = 17;
	localparam int RGB_W       = 24;
	localparam int QPOS_W      = IDX_W + 16;
	localparam int ANC_W       = POS_W + RGB_W;

	localparam logic [SIZE_W-1:0] DEF_SIZE = SIZE_W'(256);
	localparam logic [4:0]        DEF_PTS  = 5'd2;

	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_PTS  = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_GEN  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [3:0]        slot;
		logic [POS_W-1:0]  pos;
		logic [RGB_W-1:0]  rgb;
		logic [IDX_W-1:0]  idx;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;
endpackage
`default_nettype wire

[sv/gpg_ram.sv]
`default_nettype none
module gpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[sv/gpg_front.sv]
`default_nettype none
module gpg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  gpg_pkg::item_t  in_item,
	output gpg_pkg::qhead_t head,
	input  logic            pop
);
	import gpg_pkg::*;

	item_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       take;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign take      = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wr_q == rd_q))
		else $error("empty queue with pointers apart");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !take) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("push lost");
endmodule
`default_nettype wire

[sv/gpg_back.sv]
`default_nettype none
module gpg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gpg_pkg::qhead_t             head,
	output logic                        pop,
	input  logic [gpg_pkg::SIZE_W-1:0]  palette_size,
	input  logic [4:0]                  point_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [gpg_pkg::IDX_W-1:0]   out_index,
	output logic [31:0]                 abgr_color
);
	import gpg_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_ADV  = 4'd2;
	localparam logic [3:0] S_ADVW = 4'd3;
	localparam logic [3:0] S_SEL  = 4'd4;
	localparam logic [3:0] S_SGLW = 4'd5;
	localparam logic [3:0] S_RD1  = 4'd6;
	localparam logic [3:0] S_RD1W = 4'd7;
	localparam logic [3:0] S_MUL1 = 4'd8;
	localparam logic [3:0] S_MUL2 = 4'd9;
	localparam logic [3:0] S_BLD  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0]          state_q;
	logic [CNT_W-1:0]    p1_q;
	logic [CNT_W-1:0]    pts_q;
	logic [IDX_W-1:0]    size_m1_q;
	logic [IDX_W-1:0]    idx_q;
	logic [QPOS_W-1:0]   div_q;
	logic [IDX_W-1:0]    rem_q;
	logic [4:0]          cnt_q;
	logic [POS_W-1:0]    a0_q;
	logic [RGB_W-1:0]    c0_q;
	logic [RGB_W-1:0]    c1_q;
	logic [POS_W-1:0]    len_q;
	logic [POS_W-1:0]    d_q;
	logic [24:0]         prod_q [3];
	logic [24:0]         brem_q [3];
	logic [7:0]          quo_q  [3];
	logic [23:0]         den_q;
	logic [RGB_W-1:0]    col_q;

	logic                we;
	logic [SLOT_W-1:0]   raddr;
	logic [ANC_W-1:0]    rdata;
	logic [POS_W-1:0]    r_pos;
	logic [RGB_W-1:0]    r_rgb;
	logic [SIZE_W-1:0]   size_c;
	logic [CNT_W-1:0]    pts_c;
	logic [IDX_W:0]      trial;
	logic                tbit;
	logic [QPOS_W-1:0]   dfull;
	logic                out_free;

	assign r_pos    = rdata[ANC_W-1:RGB_W];
	assign r_rgb    = rdata[RGB_W-1:0];
	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == S_IDLE);
	assign we       = pop && head.valid && (head.item.cmd == CMD_LOAD);

	gpg_ram #(.WIDTH(ANC_W), .DEPTH(MAX_POINTS)) u_anchors (
		.clk   (clk),
		.we    (we),
		.waddr (head.item.slot[SLOT_W-1:0]),
		.wdata ({head.item.pos, head.item.rgb}),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (palette_size < SIZE_W'(2)) begin
			size_c = SIZE_W'(2);
		end else if (palette_size > SIZE_W'(MAX_ENTRIES)) begin
			size_c = SIZE_W'(MAX_ENTRIES);
		end else begin
			size_c = palette_size;
		end
		if (point_count < 5'd1) begin
			pts_c = CNT_W'(1);
		end else if (point_count > 5'(MAX_POINTS)) begin
			pts_c = CNT_W'(MAX_POINTS);
		end else begin
			pts_c = point_count[CNT_W-1:0];
		end
		trial = {rem_q, div_q[QPOS_W-1]};
		tbit  = (trial >= {1'b0, size_m1_q});
		dfull = (div_q > QPOS_W'(a0_q)) ? div_q - QPOS_W'(a0_q) : '0;
	end

	always_comb begin
		case (state_q)
			S_ADV:   raddr = p1_q[SLOT_W-1:0];
			S_SEL: begin
				if (p1_q == '0) begin
					raddr = '0;
				end else if (p1_q >= pts_q) begin
					raddr = SLOT_W'(pts_q - CNT_W'(1));
				end else begin
					raddr = SLOT_W'(p1_q - CNT_W'(1));
				end
			end
			S_RD1:   raddr = p1_q[SLOT_W-1:0];
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q     <= head.item.idx;
				div_q     <= {head.item.idx, 16'd0};
				rem_q     <= '0;
				size_m1_q <= IDX_W'(size_c - SIZE_W'(1));
				pts_q     <= pts_c;
			end
			S_DIV: begin
				rem_q <= tbit ? IDX_W'(trial - {1'b0, size_m1_q}) : trial[IDX_W-1:0];
				div_q <= {div_q[QPOS_W-2:0], tbit};
			end
			S_SGLW: col_q <= r_rgb;
			S_RD1: begin
				a0_q <= r_pos;
				c0_q <= r_rgb;
			end
			S_RD1W: begin
				col_q <= r_rgb;
				c1_q  <= r_rgb;
				len_q <= r_pos - a0_q;
				d_q   <= (dfull > QPOS_W'(r_pos - a0_q)) ? r_pos - a0_q : dfull[POS_W-1:0];
			end
			S_MUL1: begin
				for (int k = 0; k < 3; k++) begin
					prod_q[k] <= 25'(c0_q[8*k +: 8] * (len_q - d_q));
				end
			end
			S_MUL2: begin
				for (int k = 0; k < 3; k++) begin
					brem_q[k] <= prod_q[k] + 25'(c1_q[8*k +: 8] * d_q);
				end
				den_q <= {len_q, 7'd0};
			end
			S_BLD: begin
				for (int k = 0; k < 3; k++) begin
					if (brem_q[k] >= {1'b0, den_q}) begin
						brem_q[k] <= brem_q[k] - {1'b0, den_q};
						quo_q[k]  <= {quo_q[k][6:0], 1'b1};
					end else begin
						quo_q[k]  <= {quo_q[k][6:0], 1'b0};
					end
				end
				den_q <= den_q >> 1;
			end
			S_FIN: col_q <= {quo_q[2], quo_q[1], quo_q[0]};
			default: ;
		endcase
		if (state_q == S_OUT && out_free) begin
			out_index  <= idx_q;
			abgr_color <= {8'hFF, col_q[7:0], col_q[15:8], col_q[23:16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			p1_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (head.valid && head.item.cmd == CMD_GEN) begin
						if (head.item.idx == '0) begin
							p1_q <= '0;
						end
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QPOS_W - 1)) begin
						state_q <= S_ADV;
					end
				end
				S_ADV:  state_q <= (p1_q < pts_q) ? S_ADVW : S_SEL;
				S_ADVW: begin
					if (div_q > QPOS_W'(r_pos)) begin
						p1_q <= p1_q + CNT_W'(1);
					end
					state_q <= S_SEL;
				end
				S_SEL:  state_q <= (p1_q == '0 || p1_q >= pts_q) ? S_SGLW : S_RD1;
				S_SGLW: state_q <= S_OUT;
				S_RD1:  state_q <= S_RD1W;
				S_RD1W: state_q <= (r_pos <= a0_q) ? S_OUT : S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					cnt_q   <= '0;
					state_q <= S_BLD;
				end
				S_BLD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7) begin
						state_q <= S_FIN;
					end
				end
				S_FIN:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) p1_q <= CNT_W'(MAX_POINTS))
		else $error("segment pointer past anchors");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> out_valid)
		else $error("finished item not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1) |-> (len_q != '0 && d_q <= len_q))
		else $error("blend operands invalid");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (size_m1_q != '0))
		else $error("zero divisor");
endmodule
`default_nettype wire

[sv/gradient_palette_generator.sv]
// channel  | handshake               | payload
// cfg      | psel/penable/pready     | paddr, pwdata, prdata (0: palette_size, 4: point_count)
// in       | in_valid / in_stall     | cmd, slot, anchor_pos, anchor_rgb, entry_index
// out      | out_valid / out_stall   | out_index, abgr_color
// A load item writes its anchor to the anchor memory when the back end takes it; a generate
// item passes through the queue and the back end, which runs the 28-step serial position
// divider and, when it blends two anchors, the 8-step blend divider.
// A two-item queue lets new items enter while the back end works.
// arst_n clears control state, the registers to their defaults, and the segment pointer.
// out_stall holds the result register; the back end waits only to deliver the next one.
`default_nettype none
module gradient_palette_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [3:0]                  slot,
	input  logic [gpg_pkg::POS_W-1:0]   anchor_pos,
	input  logic [gpg_pkg::RGB_W-1:0]   anchor_rgb,
	input  logic [gpg_pkg::IDX_W-1:0]   entry_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [gpg_pkg::IDX_W-1:0]   out_index,
	output logic [31:0]                 abgr_color
);
	import gpg_pkg::*;

	logic [SIZE_W-1:0] palette_size_q;
	logic [4:0]        point_count_q;
	item_t             in_item;
	qhead_t            head;
	logic              pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIZE) ? 32'(palette_size_q) : 32'(point_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= DEF_SIZE;
			point_count_q  <= DEF_PTS;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_SIZE) begin
				palette_size_q <= pwdata[SIZE_W-1:0];
			end else begin
				point_count_q <= pwdata[4:0];
			end
		end
	end

	assign in_item = '{cmd: cmd, slot: slot, pos: anchor_pos, rgb: anchor_rgb,
		idx: entry_index};

	gpg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	gpg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.palette_size (palette_size_q),
		.point_count  (point_count_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_index    (out_index),
		.abgr_color   (abgr_color)
	);
endmodule
`default_nettype wire
